>>> rtl/core/bpa_pkg.sv
package bpa_pkg;

    localparam int unsigned MAX_PAGES_DEF    = 65536;
    localparam int unsigned RESERVED_PAGES_DEF = 256;
    localparam int unsigned PAGE_SHIFT       = 12;
    localparam int unsigned ADDR_W           = 64;
    localparam int unsigned COUNT_W          = 32;
    localparam int unsigned TOTAL_W          = 17;

    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_SEED  = 2'd1;
    localparam logic [1:0] REQ_ALLOC = 2'd2;
    localparam logic [1:0] REQ_FREE  = 2'd3;

    typedef struct packed {
        logic eligible;
        logic free;
    } page_bits_t;

endpackage

>>> rtl/core/bitmap_page_allocator.sv
// Bitmap page allocator: one request beat in, one result beat out.
// Requests: clear maps, seed a usable region, allocate a run of pages, free a run.
// Input and output channels use valid/ready; in_ready is high only while idle.
// Each result carries status, allocated base byte address, free and managed totals.
// The page maps sit in one memory with one entry per page, one read port and one
// write port; the sequencer reads one page and writes another in the same cycle.
// Each request passes through setup states and then visits pages in order:
//   clear  - sweeps the whole memory,
//   seed   - visits the pages at or above the reserved pages,
//   alloc  - scans pages over both passes, then writes the run,
//   free   - checks the run, then writes it.
// Throughput is one request at a time; set by the one-page-per-cycle memory port.
// After reset the block sweeps the memory to zero before in_ready rises;
// all counters reset to zero.
// A finished result sits in an output register; while the receiver stalls the
// block takes the next request and holds only when that one is also finished.
module bitmap_page_allocator #(
    parameter int unsigned MAX_PAGES          = bpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned RESERVED_LOW_PAGES = bpa_pkg::RESERVED_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic [bpa_pkg::ADDR_W-1:0]     address,
    input  logic [bpa_pkg::COUNT_W-1:0]    page_count,
    input  logic [bpa_pkg::ADDR_W-1:0]     max_address,
    input  logic                           region_usable,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           status,
    output logic [bpa_pkg::ADDR_W-1:0]     base_address,
    output logic [bpa_pkg::TOTAL_W-1:0]    free_pages,
    output logic [bpa_pkg::TOTAL_W-1:0]    managed_pages
);

    localparam int unsigned PW  = $clog2(MAX_PAGES + 1);
    localparam int unsigned AW  = $clog2(MAX_PAGES);
    localparam int unsigned PS  = bpa_pkg::PAGE_SHIFT;
    localparam int unsigned AHW = bpa_pkg::ADDR_W - PS;
    localparam logic [PW-1:0]  MAXP = PW'(MAX_PAGES);
    localparam logic [PW-1:0]  RESP = PW'(RESERVED_LOW_PAGES);
    localparam logic [AHW-1:0] MAXP_WIDE = AHW'(MAX_PAGES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLEAR = 4'd1;
    localparam logic [3:0] S_PREP  = 4'd2;
    localparam logic [3:0] S_SEED  = 4'd3;
    localparam logic [3:0] S_SCAN  = 4'd4;
    localparam logic [3:0] S_CHECK = 4'd5;
    localparam logic [3:0] S_FILL  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]                   state_reg, state_next;
    logic                         boot_reg, boot_next;
    logic [1:0]                   req_reg, req_next;
    logic [bpa_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [bpa_pkg::COUNT_W-1:0]  cnt_in_reg, cnt_in_next;
    logic [bpa_pkg::ADDR_W-1:0]   maxa_reg, maxa_next;
    logic                         usable_reg, usable_next;

    logic [PW-1:0] p_reg, p_next;
    logic [PW-1:0] hi_reg, hi_next;
    logic [PW-1:0] q_reg, q_next;
    logic          pend_reg, pend_next;
    logic [PW-1:0] run_reg, run_next;
    logic [PW-1:0] start_reg, start_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [PW-1:0] cur_reg, cur_next;
    logic          pass_reg, pass_next;
    logic          fill_free_reg, fill_free_next;
    logic          st_reg, st_next;
    logic [bpa_pkg::ADDR_W-1:0] base_reg, base_next;

    logic [PW-1:0] free_total_reg, free_total_next;
    logic [PW-1:0] managed_reg, managed_next;
    logic [PW-1:0] cursor_reg, cursor_next;
    logic [PW-1:0] highest_reg, highest_next;

    logic                         ovalid_reg, ovalid_next;
    logic                         ostatus_reg, ostatus_next;
    logic [bpa_pkg::ADDR_W-1:0]   obase_reg, obase_next;
    logic [bpa_pkg::TOTAL_W-1:0]  ofree_reg, ofree_next;
    logic [bpa_pkg::TOTAL_W-1:0]  omanaged_reg, omanaged_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    bpa_pkg::page_bits_t wr_data;
    logic                rd_en;
    bpa_pkg::page_bits_t rd_data;

    logic [AHW-1:0] page_hi;
    logic [AHW-1:0] maxa_page;
    logic [PW-1:0]  first_pg;
    logic [PW-1:0]  room;
    logic [PW-1:0]  seed_len;
    logic [PW-1:0]  seed_last;
    logic [PW-1:0]  seed_lo;
    logic [PW-1:0]  limit;
    logic [PW-1:0]  run_inc;
    logic           aligned;

    bpa_page_map #(
        .DEPTH (MAX_PAGES),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (p_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = ovalid_reg;
    assign status        = ostatus_reg;
    assign base_address  = obase_reg;
    assign free_pages    = ofree_reg;
    assign managed_pages = omanaged_reg;

    assign page_hi   = addr_reg[bpa_pkg::ADDR_W-1:PS];
    assign maxa_page = maxa_reg[bpa_pkg::ADDR_W-1:PS];
    assign aligned   = (addr_reg[PS-1:0] == '0);
    assign first_pg  = addr_reg[PS +: PW];
    assign room      = MAXP - first_pg;
    assign seed_len  = (cnt_in_reg < bpa_pkg::COUNT_W'(room)) ? PW'(cnt_in_reg) : room;
    assign seed_last = first_pg + seed_len;
    assign seed_lo   = (first_pg < RESP) ? RESP : first_pg;
    assign limit     = ((maxa_reg != '0) && (maxa_page < AHW'(highest_reg)))
                       ? PW'(maxa_page) : highest_reg;
    assign run_inc   = run_reg + PW'(1);

    always_comb
    begin
        state_next      = state_reg;
        boot_next       = boot_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        cnt_in_next     = cnt_in_reg;
        maxa_next       = maxa_reg;
        usable_next     = usable_reg;
        p_next          = p_reg;
        hi_next         = hi_reg;
        q_next          = q_reg;
        pend_next       = 1'b0;
        run_next        = run_reg;
        start_next      = start_reg;
        cnt_next        = cnt_reg;
        cur_next        = cur_reg;
        pass_next       = pass_reg;
        fill_free_next  = fill_free_reg;
        st_next         = st_reg;
        base_next       = base_reg;
        free_total_next = free_total_reg;
        managed_next    = managed_reg;
        cursor_next     = cursor_reg;
        highest_next    = highest_reg;
        ovalid_next     = ovalid_reg;
        ostatus_next    = ostatus_reg;
        obase_next      = obase_reg;
        ofree_next      = ofree_reg;
        omanaged_next   = omanaged_reg;
        wr_en           = 1'b0;
        wr_addr         = p_reg[AW-1:0];
        wr_data         = '0;
        rd_en           = 1'b0;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = req_type;
                    addr_next   = address;
                    cnt_in_next = page_count;
                    maxa_next   = max_address;
                    usable_next = region_usable;
                    state_next  = S_PREP;
                end
            end
            S_CLEAR:
            begin
                if (p_reg < MAXP)
                begin
                    wr_en  = 1'b1;
                    p_next = p_reg + PW'(1);
                end
                else
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_DONE;
                end
            end
            S_PREP:
            begin
                st_next   = 1'b1;
                base_next = '0;
                run_next  = '0;
                pass_next = 1'b0;
                case (req_reg)
                    bpa_pkg::REQ_CLEAR:
                    begin
                        st_next         = 1'b0;
                        free_total_next = '0;
                        managed_next    = '0;
                        cursor_next     = '0;
                        highest_next    = '0;
                        p_next          = '0;
                        state_next      = S_CLEAR;
                    end
                    bpa_pkg::REQ_SEED:
                    begin
                        if (!usable_reg || !aligned || page_hi >= MAXP_WIDE)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            st_next    = 1'b0;
                            p_next     = seed_lo;
                            hi_next    = seed_last;
                            state_next = S_SEED;
                        end
                    end
                    bpa_pkg::REQ_ALLOC:
                    begin
                        if (cnt_in_reg == '0
                            || cnt_in_reg > bpa_pkg::COUNT_W'(free_total_reg)
                            || cnt_in_reg > bpa_pkg::COUNT_W'(limit))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cnt_next = PW'(cnt_in_reg);
                            if (cnt_in_reg == bpa_pkg::COUNT_W'(1) && cursor_reg < limit)
                            begin
                                cur_next = cursor_reg;
                                p_next   = cursor_reg;
                            end
                            else
                            begin
                                cur_next = RESP;
                                p_next   = RESP;
                            end
                            hi_next    = limit;
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        if (cnt_in_reg == '0 || !aligned || page_hi >= MAXP_WIDE
                            || cnt_in_reg > bpa_pkg::COUNT_W'(room))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cnt_next   = PW'(cnt_in_reg);
                            start_next = first_pg;
                            p_next     = first_pg;
                            hi_next    = first_pg + PW'(cnt_in_reg);
                            state_next = S_CHECK;
                        end
                    end
                endcase
            end
            S_SEED:
            begin
                if (pend_reg && !rd_data.eligible)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = q_reg[AW-1:0];
                    wr_data         = '{eligible: 1'b1, free: 1'b1};
                    free_total_next = free_total_reg + PW'(1);
                    managed_next    = managed_reg + PW'(1);
                end
                if (p_reg < hi_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    q_next    = p_reg;
                    p_next    = p_reg + PW'(1);
                end
                else if (!pend_reg)
                begin
                    if (hi_reg > highest_reg)
                    begin
                        highest_next = hi_reg;
                    end
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (pend_reg && rd_data.free && run_inc == cnt_reg)
                begin
                    if (run_reg == '0)
                    begin
                        start_next = q_reg;
                        p_next     = q_reg;
                        hi_next    = q_reg + cnt_reg;
                    end
                    else
                    begin
                        p_next  = start_reg;
                        hi_next = start_reg + cnt_reg;
                    end
                    fill_free_next = 1'b0;
                    state_next     = S_FILL;
                end
                else
                begin
                    if (pend_reg)
                    begin
                        if (!rd_data.free)
                        begin
                            run_next = '0;
                        end
                        else
                        begin
                            if (run_reg == '0)
                            begin
                                start_next = q_reg;
                            end
                            run_next = run_inc;
                        end
                    end
                    if (p_reg < hi_reg)
                    begin
                        rd_en     = 1'b1;
                        pend_next = 1'b1;
                        q_next    = p_reg;
                        p_next    = p_reg + PW'(1);
                    end
                    else if (!pend_reg)
                    begin
                        if (pass_reg)
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            pass_next = 1'b1;
                            run_next  = '0;
                            p_next    = RESP;
                            hi_next   = cur_reg;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                if (pend_reg && (!rd_data.eligible || rd_data.free))
                begin
                    state_next = S_DONE;
                end
                else if (p_reg < hi_reg)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    q_next    = p_reg;
                    p_next    = p_reg + PW'(1);
                end
                else if (!pend_reg)
                begin
                    p_next         = start_reg;
                    fill_free_next = 1'b1;
                    state_next     = S_FILL;
                end
            end
            S_FILL:
            begin
                if (p_reg < hi_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = '{eligible: 1'b1, free: fill_free_reg};
                    p_next  = p_reg + PW'(1);
                end
                else
                begin
                    st_next = 1'b0;
                    if (fill_free_reg)
                    begin
                        free_total_next = free_total_reg + cnt_reg;
                        if (start_reg < cursor_reg)
                        begin
                            cursor_next = start_reg;
                        end
                    end
                    else
                    begin
                        free_total_next = free_total_reg - cnt_reg;
                        cursor_next     = hi_reg;
                        base_next       = bpa_pkg::ADDR_W'(start_reg) << PS;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next   = 1'b1;
                    ostatus_next  = st_reg;
                    obase_next    = base_reg;
                    ofree_next    = bpa_pkg::TOTAL_W'(free_total_reg);
                    omanaged_next = bpa_pkg::TOTAL_W'(managed_reg);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            boot_reg       <= 1'b1;
            p_reg          <= '0;
            pend_reg       <= 1'b0;
            free_total_reg <= '0;
            managed_reg    <= '0;
            cursor_reg     <= '0;
            highest_reg    <= '0;
            ovalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            boot_reg       <= boot_next;
            p_reg          <= p_next;
            pend_reg       <= pend_next;
            free_total_reg <= free_total_next;
            managed_reg    <= managed_next;
            cursor_reg     <= cursor_next;
            highest_reg    <= highest_next;
            ovalid_reg     <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        addr_reg      <= addr_next;
        cnt_in_reg    <= cnt_in_next;
        maxa_reg      <= maxa_next;
        usable_reg    <= usable_next;
        hi_reg        <= hi_next;
        q_reg         <= q_next;
        run_reg       <= run_next;
        start_reg     <= start_next;
        cnt_reg       <= cnt_next;
        cur_reg       <= cur_next;
        pass_reg      <= pass_next;
        fill_free_reg <= fill_free_next;
        st_reg        <= st_next;
        base_reg      <= base_next;
        ostatus_reg   <= ostatus_next;
        obase_reg     <= obase_next;
        ofree_reg     <= ofree_next;
        omanaged_reg  <= omanaged_next;
    end

endmodule

>>> rtl/core/bpa_page_map.sv
module bpa_page_map #(
    parameter int unsigned DEPTH = bpa_pkg::MAX_PAGES_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bpa_pkg::page_bits_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output bpa_pkg::page_bits_t rd_data
);

    bpa_pkg::page_bits_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned NPAGES = bpa_pkg::MAX_PAGES_DEF;
    localparam int unsigned RSV    = bpa_pkg::RESERVED_PAGES_DEF;
    localparam int unsigned PSH    = bpa_pkg::PAGE_SHIFT;
    localparam int unsigned CYCLE_LIMIT = 20000000;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] addr;
        logic [31:0] cnt;
        logic [63:0] maxa;
        logic        usable;
    } request_t;

    typedef struct {
        logic        status;
        logic [63:0] base;
        logic [16:0] free_n;
        logic [16:0] managed_n;
    } result_t;

    typedef struct {
        logic [63:0] base;
        logic [31:0] cnt;
    } run_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [63:0] address;
    logic [31:0] page_count;
    logic [63:0] max_address;
    logic        region_usable;
    logic        out_valid;
    logic        out_ready;
    logic        status;
    logic [63:0] base_address;
    logic [16:0] free_pages;
    logic [16:0] managed_pages;

    bitmap_page_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .req_type(req_type), .address(address), .page_count(page_count),
        .max_address(max_address), .region_usable(region_usable),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .base_address(base_address),
        .free_pages(free_pages), .managed_pages(managed_pages)
    );

    // shadow allocator state
    bit          page_free [NPAGES];
    bit          page_elig [NPAGES];
    int unsigned free_cnt;
    int unsigned managed_cnt;
    int unsigned cursor;
    int unsigned top_page;

    request_t    pending_q [$];
    result_t     expected_q [$];
    run_t        live_runs [$];

    int unsigned errors;
    int unsigned checked;
    int unsigned accepted;
    int unsigned req_seen [4];
    int unsigned allocs_ok;
    int unsigned cyc;
    int unsigned hold_left;
    bit          hold_done;
    bit          quiet;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic void wipe_maps();
        for (int i = 0; i < NPAGES; i++)
        begin
            page_free[i] = 1'b0;
            page_elig[i] = 1'b0;
        end
        free_cnt = 0;
        managed_cnt = 0;
        cursor = 0;
        top_page = 0;
    endfunction

    function automatic logic seed_region(logic [63:0] a, logic [63:0] c, logic u);
        logic [63:0] first;
        logic [63:0] room;
        logic [63:0] last;
        if (!u || a[11:0] != 12'd0)
            return 1'b1;
        first = a >> PSH;
        if (first >= 64'(NPAGES))
            return 1'b1;
        room = 64'(NPAGES) - first;
        last = first + ((c < room) ? c : room);
        if (first < 64'(RSV))
            first = 64'(RSV);
        for (logic [63:0] p = first; p < last; p++)
        begin
            if (!page_elig[p])
            begin
                page_elig[p] = 1'b1;
                page_free[p] = 1'b1;
                free_cnt++;
                managed_cnt++;
            end
        end
        if (last > 64'(top_page))
            top_page = 32'(last);
        return 1'b0;
    endfunction

    function automatic logic alloc_run(logic [63:0] c, logic [63:0] m, output logic [63:0] b);
        logic [63:0] lim;
        logic [63:0] start_p;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] run;
        logic [63:0] st;
        b = '0;
        if (c == 0)
            return 1'b1;
        lim = 64'(top_page);
        if (m != 0 && (m >> PSH) < lim)
            lim = m >> PSH;
        if (c > 64'(free_cnt) || c > lim)
            return 1'b1;
        start_p = (c == 1 && 64'(cursor) < lim) ? 64'(cursor) : 64'(RSV);
        for (int pass = 0; pass < 2; pass++)
        begin
            lo = pass ? 64'(RSV) : start_p;
            hi = pass ? start_p : lim;
            run = 0;
            st = 0;
            for (logic [63:0] p = lo; p < hi; p++)
            begin
                if (!page_free[p])
                begin
                    run = 0;
                    continue;
                end
                if (run == 0)
                    st = p;
                run++;
                if (run == c)
                begin
                    for (logic [63:0] j = st; j < st + c; j++)
                        page_free[j] = 1'b0;
                    free_cnt -= 32'(c);
                    cursor = 32'(st + c);
                    b = st << PSH;
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic logic free_run(logic [63:0] a, logic [63:0] c);
        logic [63:0] st;
        if (c == 0 || a[11:0] != 12'd0)
            return 1'b1;
        st = a >> PSH;
        if (st >= 64'(NPAGES) || c > 64'(NPAGES) - st)
            return 1'b1;
        for (logic [63:0] p = st; p < st + c; p++)
            if (!page_elig[p] || page_free[p])
                return 1'b1;
        for (logic [63:0] p = st; p < st + c; p++)
            page_free[p] = 1'b1;
        free_cnt += 32'(c);
        if (st < 64'(cursor))
            cursor = 32'(st);
        return 1'b0;
    endfunction

    task automatic push_request(logic [1:0] r, logic [63:0] a, logic [31:0] c,
                                logic [63:0] m, logic u);
        request_t rq;
        result_t  rs;
        run_t     rn;
        rq = '{r, a, c, m, u};
        rs.base = '0;
        case (r)
            bpa_pkg::REQ_CLEAR:
            begin
                wipe_maps();
                live_runs.delete();
                rs.status = 1'b0;
            end
            bpa_pkg::REQ_SEED:  rs.status = seed_region(a, {32'd0, c}, u);
            bpa_pkg::REQ_ALLOC:
            begin
                rs.status = alloc_run({32'd0, c}, m, rs.base);
                if (!rs.status)
                begin
                    rn = '{rs.base, c};
                    live_runs.push_back(rn);
                end
            end
            default:   rs.status = free_run(a, {32'd0, c});
        endcase
        rs.free_n = free_cnt[16:0];
        rs.managed_n = managed_cnt[16:0];
        pending_q.push_back(rq);
        expected_q.push_back(rs);
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= bpa_pkg::REQ_CLEAR;
            address <= '0;
            page_count <= '0;
            max_address <= '0;
            region_usable <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accepted++;
                req_seen[req_type]++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 16))
                begin
                    rq = pending_q.pop_front();
                    in_valid <= 1'b1;
                    req_type <= rq.req;
                    address <= rq.addr;
                    page_count <= rq.cnt;
                    max_address <= rq.maxa;
                    region_usable <= rq.usable;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off once traffic is flowing
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && accepted >= 200)
        begin
            hold_left <= 3000;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        result_t rs;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                    report("unexpected beat", 64'(status), '0);
                else
                begin
                    rs = expected_q.pop_front();
                    if (status !== rs.status)
                        report("status", 64'(status), 64'(rs.status));
                    if (base_address !== rs.base)
                        report("base_address", base_address, rs.base);
                    if (free_pages !== rs.free_n)
                        report("free_pages", 64'(free_pages), 64'(rs.free_n));
                    if (managed_pages !== rs.managed_n)
                        report("managed_pages", 64'(managed_pages), 64'(rs.managed_n));
                    if (!rs.status && rs.base != 0)
                        allocs_ok++;
                end
                checked++;
            end
            out_ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 16);
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        quiet <= (cyc >= 300000 && cyc < 360000);
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_q.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [63:0] b;
        logic [31:0] c;
        logic [63:0] pg;
        int          k;
        int          pick;
        run_t        rn;
        cyc = 0;
        quiet = 1'b0;
        errors = 0;
        checked = 0;
        accepted = 0;
        allocs_ok = 0;
        req_seen = '{0, 0, 0, 0};
        rst_n = 1'b0;
        wipe_maps();

        // directed corner cases
        push_request(bpa_pkg::REQ_CLEAR, '0, '0, '0, 1'b0);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'd1, '0, 1'b0);
        push_request(bpa_pkg::REQ_SEED, 64'h100000, 32'd16, '0, 1'b0);
        push_request(bpa_pkg::REQ_SEED, 64'h100010, 32'd16, '0, 1'b1);
        push_request(bpa_pkg::REQ_SEED, 64'hFFFF_FFFF_FFFF_F000, 32'd4, '0, 1'b1);
        push_request(bpa_pkg::REQ_SEED, 64'd0, 32'd300, '0, 1'b1);
        push_request(bpa_pkg::REQ_SEED, 64'd512 << 12, 32'd300, '0, 1'b1);
        push_request(bpa_pkg::REQ_SEED, 64'd400 << 12, 32'd200, '0, 1'b1);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'd0, '0, 1'b0);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'hFFFF_FFFF, '0, 1'b0);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'd1, '0, 1'b0);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'd3, 64'd300 << 12, 1'b0);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'd200, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, 64'd300 << 12, 32'd0, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, 64'h12_3001, 32'd1, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, 64'hFFFF_FFFF_FFFF_F000, 32'd1, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, 64'd65535 << 12, 32'd2, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, 64'd100 << 12, 32'd1, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, 64'd700 << 12, 32'd1, '0, 1'b0);
        push_request(bpa_pkg::REQ_FREE, live_runs[0].base, live_runs[0].cnt, '0, 1'b0);
        push_request(bpa_pkg::REQ_SEED, 64'd65000 << 12, 32'hFFFF_FFFF, '0, 1'b1);
        push_request(bpa_pkg::REQ_ALLOC, '0, 32'd2, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_request(bpa_pkg::REQ_CLEAR, '0, '0, '0, 1'b0);

        for (int i = 0; i < 1450; i++)
        begin
            if (i == 480 || i == 960)
            begin
                push_request(bpa_pkg::REQ_CLEAR, '0, '0, '0, 1'b0);
                continue;
            end
            k = $urandom_range(99);
            if (k < 12)
            begin
                pg = 64'($urandom_range(1100));
                b = (pg << 12) | (($urandom_range(9) == 0) ? {52'd0, 12'($urandom)} : '0);
                push_request(bpa_pkg::REQ_SEED, b, $urandom_range(1, 200),
                             {$urandom, $urandom}, $urandom_range(9) != 0);
            end
            else if (k < 55)
            begin
                c = ($urandom_range(2) == 0) ? 32'($urandom_range(2, 16)) : 32'd1;
                pick = $urandom_range(3);
                if (pick == 0)
                    b = '0;
                else if (pick == 1)
                    b = {$urandom, $urandom};
                else
                    b = (64'($urandom_range(1400)) << 12) | 64'($urandom_range(4095));
                push_request(bpa_pkg::REQ_ALLOC, {$urandom, $urandom}, c, b, 1'($urandom));
            end
            else if (k < 93)
            begin
                if (live_runs.size() > 0 && $urandom_range(4) != 0)
                begin
                    pick = $urandom_range(live_runs.size() - 1);
                    rn = live_runs[pick];
                    live_runs.delete(pick);
                    push_request(bpa_pkg::REQ_FREE, rn.base, rn.cnt, {$urandom, $urandom},
                                 1'($urandom));
                end
                else
                    push_request(bpa_pkg::REQ_FREE, 64'($urandom_range(1400)) << 12,
                                 $urandom_range(1, 8), '0, 1'($urandom));
            end
            else
                push_request(2'($urandom_range(1, 3)), {$urandom, $urandom}, $urandom,
                             {$urandom, $urandom}, 1'($urandom));
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (200) @(posedge clk);

        $display("requests: %0d clear, %0d seed, %0d alloc, %0d free; %0d results checked",
                 req_seen[0], req_seen[1], req_seen[2], req_seen[3], checked);
        $display("runs handed out: %0d, mismatches: %0d", allocs_ok, errors);
        if (errors == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bpa_pkg.sv
rtl/core/bpa_page_map.sv
rtl/core/bitmap_page_allocator.sv
tb/testbench.sv
